>>> src/fpsa_pkg.sv
// Shared widths, codes and parameter defaults for the source arbiter.
package fpsa_pkg;

  localparam int NUM_SOURCES_DEF = 8;
  localparam int TIME_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int SRC_W    = 4;
  localparam int PRI_W    = 8;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int WIDX_W   = 3;
  localparam int EMSRC_W  = 3;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 32;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CIDX_W-1:0]   cidx_t;

  localparam op_t OP_SUBMIT    = 2'd0;
  localparam op_t OP_CLEAR     = 2'd1;
  localparam op_t OP_CLEAR_ALL = 2'd2;
  localparam op_t OP_ARBITRATE = 2'd3;

  localparam status_t ST_WINNER  = 2'd0;
  localparam status_t ST_NO_CAND = 2'd1;
  localparam status_t ST_BLOCKED = 2'd2;

  localparam cidx_t REG_TIMEOUT    = 2'd0;
  localparam cidx_t REG_ALLOW_NOST = 2'd1;
  localparam cidx_t REG_EM_SOURCE  = 2'd2;

  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 32'd500000;
  localparam logic [EMSRC_W-1:0] EM_SRC_RST  = 3'd7;

endpackage

>>> src/fpsa_in_if.sv
// Request channel: operation and its operands.
interface fpsa_in_if;
  import fpsa_pkg::*;

  logic              valid;
  logic              ready;
  op_t               operation;
  logic [SRC_W-1:0]  slot_sel;
  logic [PRI_W-1:0]  priority_req;
  logic [TICK_W-1:0] stamp_ticks;
  logic [TICK_W-1:0] now_ticks;
  logic              em_req;
  logic              state_valid;

  modport source (output valid, operation, slot_sel, priority_req, stamp_ticks,
                  now_ticks, em_req, state_valid, input ready);
  modport sink   (input valid, operation, slot_sel, priority_req, stamp_ticks,
                  now_ticks, em_req, state_valid, output ready);
endinterface

>>> src/fpsa_out_if.sv
// Result channel: arbitration status and winner.
interface fpsa_out_if;
  import fpsa_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [WIDX_W-1:0] winner_index;
  logic [PRI_W-1:0]  winner_priority;

  modport source (output valid, status, winner_index, winner_priority, input ready);
  modport sink   (input valid, status, winner_index, winner_priority, output ready);
endinterface

>>> src/fpsa_cfg_if.sv
// Register write channel.
interface fpsa_cfg_if;
  import fpsa_pkg::*;

  logic               valid;
  logic               ready;
  cidx_t              index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/fresh_priority_source_arbiter_unit.sv
// Top level: slot table and sequential scan arbiter with freshness timeout.
//
//  channel   | dir | handshake            | beat carries
//  ----------+-----+----------------------+------------------------------------------
//  in_ch     | in  | valid/ready          | operation, slot operands, now, mode flags
//  out_ch    | out | valid/ready          | status, winner_index, winner_priority
//  cfg_ch    | in  | valid/ready (ready=1)| register index, write data
//
//  Submit, clear and clear-all complete in the accepting cycle; no result beat.
//  Arbitrate: the accepting cycle captures now and the mode flags; S_SCAN then
//  compares one slot per cycle through one compare unit; S_FIN then loads the
//  output register. Blocked arbitrate skips S_SCAN. in_ch.ready is low outside S_IDLE.
//  A held result stalls only the final load of the next arbitrate.
//  rst_n (sync) clears slot active bits, registers to defaults, and the sequencer.
module fresh_priority_source_arbiter_unit #(
  parameter int NUM_SOURCES = fpsa_pkg::NUM_SOURCES_DEF,
  parameter int TIME_WIDTH  = fpsa_pkg::TIME_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  fpsa_in_if.sink         in_ch,
  fpsa_out_if.source      out_ch,
  fpsa_cfg_if.sink        cfg_ch
);
  import fpsa_pkg::*;

  localparam int IW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CW = (TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W;
  localparam int EW = (IW > EMSRC_W) ? IW : EMSRC_W;
  localparam int RW = SRC_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  typedef logic [TIME_WIDTH-1:0] tick_t;
  typedef logic [IW-1:0]         sidx_t;

  // registers
  logic [TICK_W-1:0]  timeout_r;
  logic               allow_r;
  logic [EMSRC_W-1:0] em_src_r;

  logic [NUM_SOURCES-1:0] active_r;
  logic [PRI_W-1:0]       pri_r   [NUM_SOURCES];
  tick_t                  stamp_r [NUM_SOURCES];

  logic [1:0]       state_r;
  sidx_t            cnt_r;
  tick_t            now_r;
  logic             emerg_r;
  logic             blocked_r;
  logic             found_r;
  logic             best_em_r;
  logic [PRI_W-1:0] best_pri_r;
  tick_t            best_st_r;
  sidx_t            best_idx_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [WIDX_W-1:0] out_idx_r;
  logic [PRI_W-1:0]  out_pri_r;

  logic             in_fire, out_free, src_ok;
  sidx_t            src_idx;
  tick_t            cur_st;
  logic [PRI_W-1:0] cur_pri;
  logic             fresh, is_em, cand, take;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign src_ok  = RW'(in_ch.slot_sel) < RW'(NUM_SOURCES);
  assign src_idx = IW'(in_ch.slot_sel);

  // shared compare unit: slot cnt_r against the running best
  assign cur_st  = stamp_r[cnt_r];
  assign cur_pri = pri_r[cnt_r];
  assign fresh   = active_r[cnt_r] && (cur_st != '0) && (cur_st <= now_r) &&
                   (CW'(now_r - cur_st) <= CW'(timeout_r));
  assign is_em   = (EW'(cnt_r) == EW'(em_src_r));
  assign cand    = fresh && (!emerg_r || is_em);

  always_comb begin
    if (!found_r) begin
      take = cand;
    end else if (is_em != best_em_r) begin
      take = cand && is_em;
    end else if (cur_pri != best_pri_r) begin
      take = cand && (cur_pri > best_pri_r);
    end else begin
      take = cand && (cur_st > best_st_r);
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      allow_r   <= 1'b0;
      em_src_r  <= EM_SRC_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TIMEOUT:    timeout_r <= TICK_W'(cfg_ch.data);
        REG_ALLOW_NOST: allow_r   <= cfg_ch.data[0];
        REG_EM_SOURCE:  em_src_r  <= cfg_ch.data[EMSRC_W-1:0];
        default: ;
      endcase
    end
  end

  // slot table; priority and stamp are only read behind the active bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (in_fire) begin
      case (in_ch.operation)
        OP_SUBMIT:    if (src_ok) active_r[src_idx] <= 1'b1;
        OP_CLEAR:     if (src_ok) active_r[src_idx] <= 1'b0;
        OP_CLEAR_ALL: active_r <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.operation == OP_SUBMIT && src_ok) begin
      pri_r[src_idx]   <= in_ch.priority_req;
      stamp_r[src_idx] <= TIME_WIDTH'(in_ch.stamp_ticks);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_FIN the output register is either reloaded or still held
      if (out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.operation == OP_ARBITRATE) begin
            now_r     <= TIME_WIDTH'(in_ch.now_ticks);
            emerg_r   <= in_ch.em_req;
            blocked_r <= !allow_r && !in_ch.state_valid;
            found_r   <= 1'b0;
            cnt_r     <= '0;
            state_r   <= (!allow_r && !in_ch.state_valid) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            found_r    <= 1'b1;
            best_em_r  <= is_em;
            best_pri_r <= cur_pri;
            best_st_r  <= cur_st;
            best_idx_r <= cnt_r;
          end
          if (cnt_r == sidx_t'(NUM_SOURCES - 1)) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (blocked_r) begin
              out_status_r <= ST_BLOCKED;
              out_idx_r    <= '0;
              out_pri_r    <= '0;
            end else if (found_r) begin
              out_status_r <= ST_WINNER;
              out_idx_r    <= WIDX_W'(best_idx_r);
              out_pri_r    <= best_pri_r;
            end else begin
              out_status_r <= ST_NO_CAND;
              out_idx_r    <= '0;
              out_pri_r    <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.winner_index    = out_idx_r;
  assign out_ch.winner_priority = out_pri_r;

endmodule

>>> dv/fpsa_winner_checker.sv
// Slot table predictor and result scoreboard for the source arbiter.
module fpsa_winner_checker (
  input  logic clk,
  input  logic rst_n,
  fpsa_in_if   in_ch,
  fpsa_out_if  out_ch,
  fpsa_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  import fpsa_pkg::*;

  localparam int NSRC = NUM_SOURCES_DEF;

  typedef struct packed {
    status_t           status;
    logic [WIDX_W-1:0] idx;
    logic [PRI_W-1:0]  pri;
  } verdict_t;

  verdict_t          winner_q[$];
  logic              slot_on  [NSRC];
  logic [PRI_W-1:0]  slot_pri [NSRC];
  logic [TICK_W-1:0] slot_ts  [NSRC];
  logic [TICK_W-1:0] tmo;
  logic              allow_nost;
  logic [EMSRC_W-1:0] em_src;
  int                errs = 0;

  function automatic void wipe(int i);
    slot_on[i]  = 1'b0;
    slot_pri[i] = '0;
    slot_ts[i]  = '0;
  endfunction

  function automatic verdict_t predict_winner(logic [TICK_W-1:0] now, logic emerg,
                                              logic sv);
    verdict_t          v;
    bit                found;
    bit                best_em;
    bit                is_em;
    bit                take;
    logic [PRI_W-1:0]  best_pri;
    logic [TICK_W-1:0] best_ts;
    v        = '0;
    found    = 1'b0;
    best_em  = 1'b0;
    best_pri = '0;
    best_ts  = '0;
    // state check comes ahead of any candidate selection
    if (!allow_nost && !sv) begin
      v.status = ST_BLOCKED;
      return v;
    end
    for (int i = 0; i < NSRC; i++) begin
      if (!slot_on[i] || slot_ts[i] == '0 || slot_ts[i] > now || (now - slot_ts[i]) > tmo)
        continue;
      is_em = (i == int'(em_src));
      if (emerg && !is_em)
        continue;
      if (!found)
        take = 1'b1;
      else if (is_em != best_em)
        take = is_em;
      else if (slot_pri[i] != best_pri)
        take = slot_pri[i] > best_pri;
      else
        take = slot_ts[i] > best_ts;   // strict: lower index keeps a full tie
      if (take) begin
        found    = 1'b1;
        v.idx    = WIDX_W'(i);
        best_pri = slot_pri[i];
        best_ts  = slot_ts[i];
        best_em  = is_em;
      end
    end
    if (found) begin
      v.status = ST_WINNER;
      v.pri    = best_pri;
    end else begin
      v.status = ST_NO_CAND;
      v.idx    = '0;
    end
    return v;
  endfunction

  function automatic void note(string msg);
    errs++;
    if (errs <= 10)
      $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    int       sidx;
    if (!rst_n) begin
      tmo        = TIMEOUT_RST;
      allow_nost = 1'b0;
      em_src     = EM_SRC_RST;
      for (int i = 0; i < NSRC; i++)
        wipe(i);
      winner_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TIMEOUT:    tmo        = cfg_ch.data;
          REG_ALLOW_NOST: allow_nost = cfg_ch.data[0];
          REG_EM_SOURCE:  em_src     = cfg_ch.data[EMSRC_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        sidx = int'(in_ch.slot_sel);
        case (in_ch.operation)
          OP_SUBMIT: begin
            if (sidx < NSRC) begin
              slot_on[sidx]  = 1'b1;
              slot_pri[sidx] = in_ch.priority_req;
              slot_ts[sidx]  = in_ch.stamp_ticks;
            end
          end
          OP_CLEAR: begin
            if (sidx < NSRC)
              wipe(sidx);
          end
          OP_CLEAR_ALL: begin
            for (int i = 0; i < NSRC; i++)
              wipe(i);
          end
          default:
            winner_q.push_back(predict_winner(in_ch.now_ticks, in_ch.em_req,
                                              in_ch.state_valid));
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (winner_q.size() == 0) begin
          note($sformatf("unexpected result beat: status=%0d idx=%0d pri=%0d",
                         out_ch.status, out_ch.winner_index, out_ch.winner_priority));
        end else begin
          want = winner_q.pop_front();
          if (out_ch.status !== want.status || out_ch.winner_index !== want.idx ||
              out_ch.winner_priority !== want.pri)
            note($sformatf({"result mismatch: exp status=%0d idx=%0d pri=%0d, ",
                            "got status=%0d idx=%0d pri=%0d"},
                           want.status, want.idx, want.pri, out_ch.status,
                           out_ch.winner_index, out_ch.winner_priority));
        end
      end
    end
    mismatches  <= errs;
    outstanding <= winner_q.size();
  end

endmodule

>>> dv/tb_fresh_priority_source_arbiter_unit.sv
// Stimulus and verdict for the source arbiter: directed cases, then random config phases.
module tb_fresh_priority_source_arbiter_unit;
  import fpsa_pkg::*;

  localparam int    LIMIT_CYCLES = 200000;
  localparam int    TAIL_CYCLES  = NUM_SOURCES_DEF + 4;
  localparam int    MAX_IDLE     = 11;
  localparam int    PHASE_ITEMS  = 62;
  localparam cidx_t REG_SPARE    = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  int                fail_count;
  int                outstanding;
  int                cycles = 0;
  bit                quiet = 1'b0;
  logic [TICK_W-1:0] cur_tmo = TIMEOUT_RST;

  always #5 clk = ~clk;

  fpsa_in_if  in_ch();
  fpsa_out_if out_ch();
  fpsa_cfg_if cfg_ch();

  fresh_priority_source_arbiter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fpsa_winner_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[fresh_priority_source_arbiter_unit] ERROR");
      $finish;
    end
  end

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(MAX_IDLE, 0);
  endfunction

  // result side: stall draw per beat, ready only lowered when a stall is drawn
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send(op_t op, logic [SRC_W-1:0] src, logic [PRI_W-1:0] pri,
                      logic [TICK_W-1:0] ts, logic [TICK_W-1:0] now, logic em, logic sv);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.slot_sel     <= src;
    in_ch.priority_req <= pri;
    in_ch.stamp_ticks  <= ts;
    in_ch.now_ticks    <= now;
    in_ch.em_req       <= em;
    in_ch.state_valid  <= sv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic submit(logic [SRC_W-1:0] src, logic [PRI_W-1:0] pri, logic [TICK_W-1:0] ts);
    send(OP_SUBMIT, src, pri, ts, $urandom, 1'($urandom_range(1, 0)),
         1'($urandom_range(1, 0)));
  endtask

  task automatic arb(logic [TICK_W-1:0] now, logic em, logic sv);
    send(OP_ARBITRATE, SRC_W'($urandom_range(15, 0)), PRI_W'($urandom_range(255, 0)),
         $urandom, now, em, sv);
  endtask

  task automatic clear(op_t op, logic [SRC_W-1:0] src);
    send(op, src, PRI_W'($urandom_range(255, 0)), $urandom, $urandom,
         1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  // drop valid, wait out every pending result plus the scan of a trailing beat
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(cidx_t idx, logic [CDATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // upper data bits of the narrow registers are junk on purpose
  task automatic load_regs(logic [TICK_W-1:0] tmo, logic allow, logic [EMSRC_W-1:0] em);
    logic [CDATA_W-1:0] junk;
    junk = $urandom;
    cfg_beat(REG_TIMEOUT, tmo);
    cfg_beat(REG_ALLOW_NOST, {junk[CDATA_W-1:1], allow});
    cfg_beat(REG_EM_SOURCE, {junk[CDATA_W-1:EMSRC_W], em});
    cfg_beat(REG_SPARE, $urandom);
    cfg_ch.valid <= 1'b0;
    cur_tmo = tmo;
  endtask

  function automatic logic [TICK_W-1:0] make_stamp(logic [TICK_W-1:0] now);
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return now + $urandom_range(20, 1);
      2:       return now - cur_tmo;
      3:       return now - cur_tmo - 1;
      4:       return $urandom;
      5, 6:    return now - $urandom_range(3, 0);
      default: return now - ((cur_tmo == 0) ? 0 : $urandom_range(cur_tmo, 0));
    endcase
  endfunction

  task automatic run_phase(int n_items);
    logic [TICK_W-1:0] now;
    logic [SRC_W-1:0]  src;
    logic [PRI_W-1:0]  pri;
    int                sel;
    now = $urandom_range(32'hFFFF_FF00, 32'h0010_0000);
    repeat (n_items) begin
      sel = $urandom_range(99, 0);
      src = ($urandom_range(9, 0) == 0) ? SRC_W'($urandom_range(15, 8)) :
                                          SRC_W'($urandom_range(7, 0));
      // narrow priorities half of the time to force ties
      pri = ($urandom_range(1, 0) != 0) ? PRI_W'($urandom_range(3, 0)) :
                                          PRI_W'($urandom_range(255, 0));
      if (sel < 45)
        submit(src, pri, make_stamp(now));
      else if (sel < 80) begin
        now = now + $urandom_range(2, 0);
        arb(($urandom_range(19, 0) == 0) ? $urandom : now, $urandom_range(4, 0) == 0,
            $urandom_range(9, 0) != 0);
      end else if (sel < 95)
        clear(OP_CLEAR, src);
      else
        clear(OP_CLEAR_ALL, src);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.operation      <= OP_SUBMIT;
    in_ch.slot_sel       <= '0;
    in_ch.priority_req   <= '0;
    in_ch.stamp_ticks    <= '0;
    in_ch.now_ticks      <= '0;
    in_ch.em_req         <= 1'b0;
    in_ch.state_valid    <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_TIMEOUT;
    cfg_ch.data    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    arb(32'd100, 1'b0, 1'b1);                  // empty table
    arb(32'd100, 1'b0, 1'b0);                  // blocked on invalid state
    submit(4'd15, 8'd255, 32'd100);            // out of range, ignored
    submit(4'd8, 8'd1, 32'd100);
    arb(32'd100, 1'b0, 1'b1);
    submit(4'd0, 8'd255, 32'hFFFF_FFFF);
    submit(4'd1, 8'd255, 32'hFFFF_FFFF);
    arb(32'hFFFF_FFFF, 1'b0, 1'b1);            // full tie, lower index
    submit(4'd7, 8'd0, 32'd1000);
    submit(4'd2, 8'd200, 32'd0);               // zero stamp never fresh
    arb(32'd1000, 1'b0, 1'b1);                 // only slot 7 fresh: zero and future stamps out
    arb(32'd1000, 1'b1, 1'b1);
    clear(OP_CLEAR, 4'd7);
    arb(32'd1000, 1'b1, 1'b1);                 // emergency mode, no emergency slot
    submit(4'd3, 8'd10, 32'd500);
    submit(4'd4, 8'd10, 32'd600);
    arb(32'd500600, 1'b0, 1'b1);               // age exactly at timeout vs past it
    arb(32'd600, 1'b0, 1'b1);                  // equal priority, newer stamp
    submit(4'd5, 8'd11, 32'd550);
    arb(32'd600, 1'b0, 1'b1);                  // higher priority over newer stamp
    clear(OP_CLEAR, 4'd12);
    clear(OP_CLEAR_ALL, 4'd0);
    arb(32'd600, 1'b1, 1'b0);
    arb(32'd600, 1'b0, 1'b1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       load_regs(32'd0, 1'b1, 3'd0);
        1:       load_regs(32'hFFFF_FFFF, 1'b0, 3'd7);
        2:       load_regs(32'd1, 1'b1, 3'd3);
        default: load_regs(($urandom_range(2, 0) == 0) ? $urandom : $urandom_range(2000, 2),
                           1'($urandom_range(1, 0)), EMSRC_W'($urandom_range(7, 0)));
      endcase
      quiet = (ph == 2);
      run_phase(PHASE_ITEMS);
      settle();
    end

    if (fail_count == 0)
      $display("[fresh_priority_source_arbiter_unit] OK");
    else
      $display("[fresh_priority_source_arbiter_unit] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/fpsa_pkg.sv
src/fpsa_in_if.sv
src/fpsa_out_if.sv
src/fpsa_cfg_if.sv
src/fresh_priority_source_arbiter_unit.sv
dv/fpsa_winner_checker.sv
dv/tb_fresh_priority_source_arbiter_unit.sv
